// ===== rtl/lsal_pkg.sv =====
package lsal_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LUX,
        ST_T_HI,
        ST_T_LO,
        ST_OPC
    } state_t;

    // Request codes.
    localparam logic [1:0] REQ_SETUP      = 2'd0;
    localparam logic [1:0] REQ_READING    = 2'd1;
    localparam logic [1:0] REQ_POWER_DOWN = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_SENS     = 2'd1;
    localparam logic [1:0] REG_MIN_SENS = 2'd2;
    localparam logic [1:0] REG_MAX_SENS = 2'd3;

    // Mode codes. The spare code behaves as auto.
    localparam logic [2:0] MODE_CONT_H    = 3'd0;
    localparam logic [2:0] MODE_CONT_H2   = 3'd1;
    localparam logic [2:0] MODE_CONT_L    = 3'd2;
    localparam logic [2:0] MODE_ONCE_H    = 3'd3;
    localparam logic [2:0] MODE_ONCE_H2   = 3'd4;
    localparam logic [2:0] MODE_ONCE_L    = 3'd5;
    localparam logic [2:0] MODE_AUTO      = 3'd6;
    localparam logic [2:0] MODE_AUTO_ALT  = 3'd7;

    // Sensor command bytes.
    localparam logic [7:0] CMD_POWER_DOWN = 8'h00;
    localparam logic [7:0] CMD_CONT_H     = 8'h10;
    localparam logic [7:0] CMD_CONT_H2    = 8'h11;
    localparam logic [7:0] CMD_CONT_L     = 8'h13;
    localparam logic [7:0] CMD_ONCE_H     = 8'h20;
    localparam logic [7:0] CMD_ONCE_H2    = 8'h21;
    localparam logic [7:0] CMD_ONCE_L     = 8'h23;
    localparam logic [4:0] CMD_TIME_HI    = 5'b01000;
    localparam logic [2:0] CMD_TIME_LO    = 3'b011;
    localparam logic [4:0] TIME_LO_MASK   = 5'b11111;

    localparam logic [15:0] LUX_SCALE     = 16'd57500;
    localparam logic [26:0] LUX_MAX       = 27'h7FF_FFFF;
    localparam logic [26:0] LUX_UP_THRESH = 27'd7200000;
    localparam logic [26:0] LUX_DN_THRESH = 27'd7000000;

    localparam logic [7:0] SENS_RESET     = 8'd69;
    localparam logic [7:0] MIN_SENS_RESET = 8'd31;
    localparam logic [7:0] MAX_SENS_RESET = 8'd254;
    localparam logic [8:0] EFF_RESET      = 9'd69;

    function automatic logic is_auto(input logic [2:0] mode);
        logic r;
        case (mode) inside
            MODE_AUTO, MODE_AUTO_ALT: r = 1'b1;
            default:                  r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] mode_opcode(input logic [2:0] mode);
        logic [7:0] r;
        unique case (mode)
            MODE_CONT_H:  r = CMD_CONT_H;
            MODE_CONT_H2: r = CMD_CONT_H2;
            MODE_CONT_L:  r = CMD_CONT_L;
            MODE_ONCE_H:  r = CMD_ONCE_H;
            MODE_ONCE_H2: r = CMD_ONCE_H2;
            MODE_ONCE_L:  r = CMD_ONCE_L;
            default:      r = CMD_CONT_H2;
        endcase
        return r;
    endfunction

    // Effective sensitivity that a measurement time value gives in a mode.
    function automatic logic [8:0] eff_of(input logic [2:0] mode, input logic [7:0] s,
                                          input logic [7:0] max_s);
        logic dbl;
        dbl = (mode == MODE_CONT_H2) || (mode == MODE_ONCE_H2) ||
              (is_auto(mode) && (s == max_s));
        return dbl ? {s, 1'b0} : {1'b0, s};
    endfunction

endpackage

// ===== rtl/light_sensor_autorange_lux_core.sv =====
// Channel   Direction  Handshake          Beat payload
// in        input      in_valid/in_stall  req_type, raw_count
// out       output     out_valid/out_stall kind, command_byte, lux_scaled, last
// cfg       input      cfg_wr_en          cfg_index, cfg_data
//
// One item at a time. A reading is multiplied on acceptance, divided at one bit per
// cycle, then emits one beat per cycle while the output does not stall: lux, plus
// time and opcode beats on a range switch. Setup: both time bytes, then the opcode.
// Output stalls hold the sequencer in its current emit state. Reset restores
// the register defaults and an effective sensitivity of 69.
module light_sensor_autorange_lux_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] raw_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  command_byte,
    output logic [26:0] lux_scaled,
    output logic        last,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    lsal_pkg::state_t state_reg, state_next;

    logic [2:0]  mode_reg;
    logic [7:0]  sens_reg;
    logic [7:0]  min_sens_reg;
    logic [7:0]  max_sens_reg;
    logic [8:0]  eff_reg;

    logic [7:0]  time_reg;
    logic [7:0]  opc_reg;
    logic [31:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [4:0]  cnt_reg;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  cmd_reg;
    logic [26:0] lux_reg;
    logic        last_reg;

    logic        in_accept;
    logic        out_free;
    logic        auto_mode;
    logic [26:0] lux_sat;
    logic        switch_up;
    logic        switch_dn;

    logic [9:0]  rem_shift;
    logic        div_ge;
    logic [9:0]  rem_diff;

    logic        emit_en;
    logic        emit_kind;
    logic [7:0]  emit_cmd;
    logic [26:0] emit_lux;
    logic        emit_last;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign auto_mode = lsal_pkg::is_auto(mode_reg);

    // Quotients that overflow the field, including a zero divisor, saturate.
    assign lux_sat   = (|quo_reg[31:27]) ? lsal_pkg::LUX_MAX : quo_reg[26:0];
    assign switch_up = auto_mode && (lux_sat < lsal_pkg::LUX_UP_THRESH) &&
                       (eff_reg == {1'b0, min_sens_reg});
    assign switch_dn = auto_mode && !switch_up && (lux_sat >= lsal_pkg::LUX_DN_THRESH) &&
                       (eff_reg == {max_sens_reg, 1'b0});

    // Restoring divider step: one quotient bit per cycle.
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign div_ge    = rem_shift >= {1'b0, eff_reg};
    assign rem_diff  = rem_shift - {1'b0, eff_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsal_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (req_type)
                        lsal_pkg::REQ_SETUP:      state_next = lsal_pkg::ST_T_HI;
                        lsal_pkg::REQ_READING:    state_next = lsal_pkg::ST_DIV;
                        lsal_pkg::REQ_POWER_DOWN: state_next = lsal_pkg::ST_OPC;
                        default:                  state_next = lsal_pkg::ST_IDLE;
                    endcase
                end
            end
            lsal_pkg::ST_DIV:
            begin
                if (cnt_reg == '1)
                    state_next = lsal_pkg::ST_LUX;
            end
            lsal_pkg::ST_LUX:
            begin
                if (out_free)
                    state_next = (switch_up || switch_dn) ? lsal_pkg::ST_T_HI
                                                          : lsal_pkg::ST_IDLE;
            end
            lsal_pkg::ST_T_HI:
            begin
                if (out_free)
                    state_next = lsal_pkg::ST_T_LO;
            end
            lsal_pkg::ST_T_LO:
            begin
                if (out_free)
                    state_next = lsal_pkg::ST_OPC;
            end
            lsal_pkg::ST_OPC:
            begin
                if (out_free)
                    state_next = lsal_pkg::ST_IDLE;
            end
            default: state_next = lsal_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = state_reg != lsal_pkg::ST_IDLE;
        emit_en   = 1'b0;
        emit_kind = 1'b0;
        emit_cmd  = '0;
        emit_lux  = '0;
        emit_last = 1'b0;
        unique case (state_reg)
            lsal_pkg::ST_LUX:
            begin
                emit_en   = out_free;
                emit_kind = 1'b1;
                emit_lux  = lux_sat;
                emit_last = !(switch_up || switch_dn);
            end
            lsal_pkg::ST_T_HI:
            begin
                emit_en  = out_free;
                emit_cmd = {lsal_pkg::CMD_TIME_HI, time_reg[7:5]};
            end
            lsal_pkg::ST_T_LO:
            begin
                emit_en  = out_free;
                emit_cmd = {lsal_pkg::CMD_TIME_LO, time_reg[4:0] & lsal_pkg::TIME_LO_MASK};
            end
            lsal_pkg::ST_OPC:
            begin
                emit_en   = out_free;
                emit_cmd  = opc_reg;
                emit_last = 1'b1;
            end
            default:
            begin
                emit_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsal_pkg::ST_IDLE;
            mode_reg      <= lsal_pkg::MODE_AUTO;
            sens_reg      <= lsal_pkg::SENS_RESET;
            min_sens_reg  <= lsal_pkg::MIN_SENS_RESET;
            max_sens_reg  <= lsal_pkg::MAX_SENS_RESET;
            eff_reg       <= lsal_pkg::EFF_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    lsal_pkg::REG_MODE:     mode_reg     <= cfg_data[2:0];
                    lsal_pkg::REG_SENS:     sens_reg     <= cfg_data;
                    lsal_pkg::REG_MIN_SENS: min_sens_reg <= cfg_data;
                    lsal_pkg::REG_MAX_SENS: max_sens_reg <= cfg_data;
                    default:                sens_reg     <= sens_reg;
                endcase
            end

            if (in_accept && (req_type == lsal_pkg::REQ_SETUP))
            begin
                if (auto_mode)
                    eff_reg <= lsal_pkg::eff_of(mode_reg, max_sens_reg, max_sens_reg);
                else
                    eff_reg <= lsal_pkg::eff_of(mode_reg, sens_reg, max_sens_reg);
            end
            else if ((state_reg == lsal_pkg::ST_LUX) && out_free)
            begin
                if (switch_up)
                    eff_reg <= lsal_pkg::eff_of(mode_reg, max_sens_reg, max_sens_reg);
                else if (switch_dn)
                    eff_reg <= lsal_pkg::eff_of(mode_reg, min_sens_reg, max_sens_reg);
            end

            if (state_reg == lsal_pkg::ST_DIV)
                cnt_reg <= cnt_reg + 5'd1;
            else
                cnt_reg <= '0;

            if (emit_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            time_reg <= auto_mode ? max_sens_reg : sens_reg;
            if (req_type == lsal_pkg::REQ_POWER_DOWN)
                opc_reg <= lsal_pkg::CMD_POWER_DOWN;
            else
                opc_reg <= lsal_pkg::mode_opcode(mode_reg);
            quo_reg <= 32'(raw_count) * 32'(lsal_pkg::LUX_SCALE);
            rem_reg <= '0;
        end
        else if (state_reg == lsal_pkg::ST_DIV)
        begin
            quo_reg <= {quo_reg[30:0], div_ge};
            rem_reg <= div_ge ? rem_diff[8:0] : rem_shift[8:0];
        end
        else if ((state_reg == lsal_pkg::ST_LUX) && out_free)
        begin
            if (switch_up)
            begin
                time_reg <= max_sens_reg;
                opc_reg  <= lsal_pkg::CMD_CONT_H2;
            end
            else if (switch_dn)
            begin
                time_reg <= min_sens_reg;
                opc_reg  <= lsal_pkg::CMD_CONT_H;
            end
        end

        if (emit_en)
        begin
            kind_reg <= emit_kind;
            cmd_reg  <= emit_cmd;
            lux_reg  <= emit_lux;
            last_reg <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign command_byte = cmd_reg;
    assign lux_scaled   = lux_reg;
    assign last         = last_reg;

    // A lux beat is only produced right after the divider has run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsal_pkg::ST_LUX) |->
            ($past(state_reg) == lsal_pkg::ST_DIV || $past(state_reg) == lsal_pkg::ST_LUX))
        else $error("lux emitted without a finished divide");

    // The final beat of an item returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_en && emit_last) |=> (state_reg == lsal_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after the last beat");

    // A setup item always starts with the high time byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (req_type == lsal_pkg::REQ_SETUP)) |=>
            (state_reg == lsal_pkg::ST_T_HI))
        else $error("setup did not start the measurement time sequence");

endmodule
